// File: rtl/mrd_pkg.sv
// ----------------------------------------------------------------------------
// mrd_pkg
// Shared types, constants and the CRC-16 byte update for the Modbus RTU
// read response deframer.
// ----------------------------------------------------------------------------
package mrd_pkg;

    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;
    localparam logic [7:0]  MAX_PAYLOAD_COUNT = 8'd250;
    localparam logic [7:0]  FUNC_CODE_RESET   = 8'h03;

    // Frame positions with a fixed meaning.
    localparam logic [7:0] POS_ADDRESS    = 8'd0;
    localparam logic [7:0] POS_FUNCTION   = 8'd1;
    localparam logic [7:0] POS_COUNT      = 8'd2;
    localparam logic [7:0] POS_VALUE_HIGH = 8'd3;
    localparam logic [7:0] POS_VALUE_LOW  = 8'd4;

    // Register indexes on the configuration port.
    localparam logic REG_CRC_CHECK_ENABLE = 1'b0;
    localparam logic REG_EXPECTED_FUNC    = 1'b1;

    typedef struct packed {
        logic       crc_check_enable;
        logic [7:0] expected_function_code;
    } t_cfg;

    typedef struct packed {
        logic        crc_good;
        logic        accepted;
        logic [15:0] distance;
    } t_result;

    // One byte of the reflected CRC-16, eight shift steps.
    function automatic logic [15:0] f_crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/mrd_cfg.sv
// ----------------------------------------------------------------------------
// mrd_cfg
// APB register file: CRC check enable and expected function code.
// ----------------------------------------------------------------------------
module mrd_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output mrd_pkg::t_cfg     o_cfg
);

    logic       r_crc_check_enable;
    logic [7:0] r_expected_function_code;
    logic       w_write;

    // Word-aligned decode: only address bit 2 selects the register.
    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_check_enable       <= 1'b0;
            r_expected_function_code <= mrd_pkg::FUNC_CODE_RESET;
        end else if (w_write) begin
            case (paddr[2])
                mrd_pkg::REG_CRC_CHECK_ENABLE: r_crc_check_enable       <= pwdata[0];
                mrd_pkg::REG_EXPECTED_FUNC:    r_expected_function_code <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            mrd_pkg::REG_CRC_CHECK_ENABLE: prdata = {31'd0, r_crc_check_enable};
            mrd_pkg::REG_EXPECTED_FUNC:    prdata = {24'd0, r_expected_function_code};
            default:                       prdata = 32'd0;
        endcase
    end

    assign o_cfg.crc_check_enable       = r_crc_check_enable;
    assign o_cfg.expected_function_code = r_expected_function_code;

endmodule

// File: rtl/mrd_in_reg.sv
// ----------------------------------------------------------------------------
// mrd_in_reg
// Input register for received bytes; refills in the cycle it is drained.
// ----------------------------------------------------------------------------
module mrd_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    output logic       o_valid,
    output logic [7:0] o_byte,
    input  logic       i_take
);

    logic       r_valid;
    logic [7:0] r_byte;

    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// File: rtl/mrd_parser.sv
// ----------------------------------------------------------------------------
// mrd_parser
// Frame position tracking, running CRC and distance capture for one byte
// per cycle while i_fire is high; emits a result on the trailing CRC byte.
// ----------------------------------------------------------------------------
module mrd_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mrd_pkg::t_cfg     i_cfg,
    input  logic              i_fire,
    input  logic [7:0]        i_byte,
    output logic              o_res_valid,
    output mrd_pkg::t_result  o_res
);

    logic [7:0]  r_pos, n_pos;
    logic [7:0]  r_cnt, n_cnt;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_crc_lo, n_crc_lo;
    logic [7:0]  r_val_hi, n_val_hi;
    logic [7:0]  r_val_lo, n_val_lo;
    logic [15:0] r_dist, n_dist;
    logic [15:0] w_crc_upd;
    logic [8:0]  w_pos9;
    logic [8:0]  w_cnt9;
    logic        w_good;
    logic        w_acc;
    logic        w_final;

    assign w_crc_upd = mrd_pkg::f_crc_feed(r_crc, i_byte);
    assign w_pos9    = {1'b0, r_pos};
    assign w_cnt9    = {1'b0, r_cnt};

    always_comb begin
        n_pos    = r_pos;
        n_cnt    = r_cnt;
        n_crc    = r_crc;
        n_crc_lo = r_crc_lo;
        n_val_hi = r_val_hi;
        n_val_lo = r_val_lo;
        n_dist   = r_dist;
        w_good   = 1'b0;
        w_acc    = 1'b0;
        w_final  = 1'b0;
        if (r_pos == mrd_pkg::POS_ADDRESS) begin
            n_crc = mrd_pkg::f_crc_feed(mrd_pkg::CRC_INIT, i_byte);
            n_pos = mrd_pkg::POS_FUNCTION;
        end else if (r_pos == mrd_pkg::POS_FUNCTION) begin
            // Hunt for the function code; other bytes leave the CRC alone.
            if (i_byte == i_cfg.expected_function_code) begin
                n_crc = w_crc_upd;
                n_pos = mrd_pkg::POS_COUNT;
            end
        end else if (r_pos == mrd_pkg::POS_COUNT) begin
            if (i_byte > mrd_pkg::MAX_PAYLOAD_COUNT) begin
                n_pos = mrd_pkg::POS_ADDRESS;
                n_cnt = 8'd0;
                n_crc = mrd_pkg::CRC_INIT;
            end else begin
                n_cnt = i_byte;
                n_crc = w_crc_upd;
                n_pos = mrd_pkg::POS_VALUE_HIGH;
            end
        end else begin
            // Short payloads take the distance from the CRC bytes as well.
            if (r_pos == mrd_pkg::POS_VALUE_HIGH) begin
                n_val_hi = i_byte;
            end
            if (r_pos == mrd_pkg::POS_VALUE_LOW) begin
                n_val_lo = i_byte;
            end
            if (w_pos9 <= w_cnt9 + 9'd2) begin
                n_crc = w_crc_upd;
                n_pos = r_pos + 8'd1;
            end else if (w_pos9 == w_cnt9 + 9'd3) begin
                n_crc_lo = i_byte;
                n_pos    = r_pos + 8'd1;
            end else begin
                w_final = 1'b1;
                w_good  = (r_crc_lo == r_crc[7:0]) && (i_byte == r_crc[15:8]);
                w_acc   = !i_cfg.crc_check_enable || w_good;
                if (w_acc) begin
                    n_dist = {n_val_hi, n_val_lo};
                end
                n_pos = mrd_pkg::POS_ADDRESS;
                n_cnt = 8'd0;
                n_crc = mrd_pkg::CRC_INIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= mrd_pkg::POS_ADDRESS;
            r_cnt    <= 8'd0;
            r_crc    <= mrd_pkg::CRC_INIT;
            r_crc_lo <= 8'd0;
            r_val_hi <= 8'd0;
            r_val_lo <= 8'd0;
            r_dist   <= 16'd0;
        end else if (i_fire) begin
            r_pos    <= n_pos;
            r_cnt    <= n_cnt;
            r_crc    <= n_crc;
            r_crc_lo <= n_crc_lo;
            r_val_hi <= n_val_hi;
            r_val_lo <= n_val_lo;
            r_dist   <= n_dist;
        end
    end

    assign o_res_valid    = i_fire && w_final;
    assign o_res.distance = n_dist;
    assign o_res.accepted = w_acc;
    assign o_res.crc_good = w_good;

`ifndef SYNTHESIS
    // The position never runs past the trailing CRC high byte.
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos > mrd_pkg::POS_COUNT) |-> ({1'b0, r_pos} <= {1'b0, r_cnt} + 9'd4))
        else $error("frame position beyond end of frame");
    // A stored byte count never exceeds the limit.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= mrd_pkg::MAX_PAYLOAD_COUNT)
        else $error("payload count above limit");
    // A completed frame restarts the hunt with a fresh CRC.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> (r_pos == mrd_pkg::POS_ADDRESS) && (r_crc == mrd_pkg::CRC_INIT))
        else $error("frame did not restart after completion");
    // A good CRC or a disabled check always accepts the frame.
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.crc_good || !i_cfg.crc_check_enable)) |-> o_res.accepted)
        else $error("frame rejected although it should be accepted");
`endif

endmodule

// File: rtl/mrd_out_reg.sv
// ----------------------------------------------------------------------------
// mrd_out_reg
// Result register holding one completed frame until the receiver takes it.
// ----------------------------------------------------------------------------
module mrd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  mrd_pkg::t_result  i_res,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_ready,
    output mrd_pkg::t_result  o_res
);

    logic             r_valid;
    mrd_pkg::t_result r_res;

    assign o_space = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// File: rtl/modbus_response_deframer.sv
// ----------------------------------------------------------------------------
// modbus_response_deframer
// Parses received Modbus RTU read responses and reports the distance field.
// ----------------------------------------------------------------------------
// Received UART bytes enter on the slave stream, one byte per transfer in
// s_axis_tdata. Each byte is stored in an input register and handled from
// there by the parser, which tracks the frame position, runs the CRC-16
// and captures the two distance bytes. On the trailing CRC byte of a frame
// one result is written into the output register and offered on the master
// stream: the held distance in m_axis_tdata, and in m_axis_tuser the flags
// accepted and crc_good. Other bytes produce no result.
// The last frame byte passes from the input register through the parser
// into the output register, which offers the result. Throughput is one
// byte per cycle while the output register has room, set by the single CRC
// byte update between the input and result registers. When the receiver
// stalls while a result is waiting, the parser holds every byte, the input
// register fills, and s_axis_tready stays low until the result is taken.
// Reset (synchronous, active low) empties both registers, restarts the frame
// hunt, clears the held distance, disables the CRC check and sets the expected
// function code to 3. The user writes registers over APB only while idle;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
module modbus_response_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] distance
    output logic [1:0]  m_axis_tuser,   // [0] accepted, [1] crc_good
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    mrd_pkg::t_cfg    w_cfg;
    mrd_pkg::t_result w_res;
    mrd_pkg::t_result w_out_res;
    logic             w_in_valid;
    logic [7:0]       w_in_byte;
    logic             w_space;
    logic             w_fire;
    logic             w_res_valid;

    mrd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // A stored byte is processed whenever a possible result has room.
    assign w_fire = w_in_valid && w_space;

    mrd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .o_valid (w_in_valid),
        .o_byte  (w_in_byte),
        .i_take  (w_fire)
    );

    mrd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_fire      (w_fire),
        .i_byte      (w_in_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    mrd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_res_valid),
        .i_res   (w_res),
        .o_space (w_space),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (w_out_res)
    );

    assign m_axis_tdata = w_out_res.distance;
    assign m_axis_tuser = {w_out_res.crc_good, w_out_res.accepted};

endmodule
